// ===== rtl/amdfs_pkg.sv =====
// Shared types and constants for the adjacency-matrix DFS order unit.
// No dependencies; imported by every module of the block.
package amdfs_pkg;

    // Vertex and count field widths fixed by the port definition
    localparam int VTX_W = 4;
    localparam int CNT_W = 5;

    // Highest vertex count the 4-bit vertex fields can address
    localparam int ADDR_LIMIT = 16;

    // Command codes on the mode port
    typedef enum logic [1:0] {
        MODE_CLEAR    = 2'd0,
        MODE_ADD_EDGE = 2'd1,
        MODE_TRAVERSE = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    // Control bundle for the adjacency row memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } adj_ctl_t;

    // Control bundle for the pending-vertex stack memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } stk_ctl_t;

endpackage

// ===== rtl/amdfs_adj_mem.sv =====
// Adjacency row memory: one neighbor bit row per vertex, synchronous read.
// Depends on amdfs_pkg. Per-row valid bits make a cleared row read as zero.
module amdfs_adj_mem
    import amdfs_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int AW   = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  adj_ctl_t        ctl,
    input  logic [AW-1:0]   addr,
    input  logic [ROWS-1:0] wr_data,
    output logic [ROWS-1:0] rd_data
);

    logic [ROWS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic [ROWS-1:0] row_valid_next;
    logic [ROWS-1:0] rd_data_reg;
    logic            rd_valid_reg;

    // Valid bits: clear drops every row at once, a write marks its row
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (ctl.clr_all)
        begin
            row_valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            row_valid_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[addr];
            end
        end
    end

    // Storage array, registered read data
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Row never written since the last clear reads as empty
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/amdfs_stack_mem.sv =====
// Pending-vertex stack storage, one vertex per entry, synchronous read.
// Depends on amdfs_pkg for the vertex width and control bundle.
module amdfs_stack_mem
    import amdfs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic             clk,
    input  stk_ctl_t         ctl,
    input  logic [AW-1:0]    addr,
    input  logic [VTX_W-1:0] wr_data,
    output logic [VTX_W-1:0] rd_data
);

    logic [VTX_W-1:0] mem [DEPTH];
    logic [VTX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/adjacency_matrix_dfs_order_unit.sv =====
// Top level of the adjacency-matrix depth-first order unit: command FSM.
// Depends on amdfs_pkg, amdfs_adj_mem and amdfs_stack_mem.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  command  | start, busy        | mode, edge_from, edge_to, start_vertex
//  result   | out_valid (strobe) | visited_vertex, last, incomplete
//  config   | cfg_we             | cfg_data (vertex_count)
//
// Clear never leaves idle; add edge does two read-modify-writes of rows.
// Traversal: per scanned vertex one row read, a scan over count row bits and
// a stack pop (S_POP, S_POPD); the run length is set by the one-bit-per-cycle
// row scan.
// Reset clears the matrix (row valid bits), control state and sets count to 16.
// Each result strobes for one cycle; the receiver cannot stall.
module adjacency_matrix_dfs_order_unit
    import amdfs_pkg::*;
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       mode,
    input  logic [VTX_W-1:0] edge_from,
    input  logic [VTX_W-1:0] edge_to,
    input  logic [VTX_W-1:0] start_vertex,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    output logic             out_valid,
    output logic [VTX_W-1:0] visited_vertex,
    output logic             last,
    output logic             incomplete
);

    // Vertices actually usable, memory geometry
    localparam int CL  = (MAX_VERTICES < ADDR_LIMIT) ? MAX_VERTICES : ADDR_LIMIT;
    localparam int AW  = $clog2(CL);
    localparam int SPW = $clog2(CL + 1);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(CL);
    localparam logic [CL-1:0]    ONE_BIT = {{(CL-1){1'b0}}, 1'b1};

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EA_RD = 9'b000000010,
        S_EA_WR = 9'b000000100,
        S_EB_RD = 9'b000001000,
        S_EB_WR = 9'b000010000,
        S_RD    = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_POP   = 9'b010000000,
        S_POPD  = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] vcount_reg, vcount_next;
    logic [VTX_W-1:0] a_reg, a_next;
    logic [VTX_W-1:0] b_reg, b_next;
    logic [VTX_W-1:0] cur_reg, cur_next;
    logic [VTX_W-1:0] pend_reg, pend_next;
    logic [CL-1:0]    visited_reg, visited_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [VTX_W-1:0] j_reg, j_next;
    logic [VTX_W-1:0] k_reg, k_next;
    logic             ov_reg, ov_next;
    logic [VTX_W-1:0] ovtx_reg, ovtx_next;
    logic             olast_reg, olast_next;
    logic             oinc_reg, oinc_next;

    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] count_m1;
    logic             accept;
    logic             scan_hit;
    logic [SPW-1:0]   sp_dec;

    adj_ctl_t         adj_ctl;
    logic [AW-1:0]    adj_addr;
    logic [CL-1:0]    adj_wr_data;
    logic [CL-1:0]    adj_rd_data;
    stk_ctl_t         stk_ctl;
    logic [AW-1:0]    stk_addr;
    logic [VTX_W-1:0] stk_wr_data;
    logic [VTX_W-1:0] stk_rd_data;

    amdfs_adj_mem #(
        .ROWS (CL),
        .AW   (AW)
    ) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (adj_ctl),
        .addr    (adj_addr),
        .wr_data (adj_wr_data),
        .rd_data (adj_rd_data)
    );

    amdfs_stack_mem #(
        .DEPTH (CL),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .ctl     (stk_ctl),
        .addr    (stk_addr),
        .wr_data (stk_wr_data),
        .rd_data (stk_rd_data)
    );

    // Effective vertex count: zero counts as one, saturate at the limit
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (vcount_reg > CNT_LIM)
        begin
            count_eff = CNT_LIM;
        end
        else
        begin
            count_eff = vcount_reg;
        end
    end

    assign count_m1 = count_eff - CNT_W'(1);
    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign scan_hit = adj_rd_data[j_reg[AW-1:0]] && !visited_reg[j_reg[AW-1:0]];
    assign sp_dec   = sp_reg - SPW'(1);

    // Command sequencer
    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        visited_next = visited_reg;
        sp_next      = sp_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        ov_next      = 1'b0;
        ovtx_next    = ovtx_reg;
        olast_next   = olast_reg;
        oinc_next    = oinc_reg;
        adj_ctl      = '0;
        adj_addr     = cur_reg[AW-1:0];
        adj_wr_data  = adj_rd_data;
        stk_ctl      = '0;
        stk_addr     = sp_reg[AW-1:0];
        stk_wr_data  = j_reg;

        if (cfg_we)
        begin
            vcount_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_CLEAR:
                        begin
                            adj_ctl.clr_all = 1'b1;
                        end
                        MODE_ADD_EDGE:
                        begin
                            a_next = edge_from;
                            b_next = edge_to;
                            if ((int'(edge_from) < MAX_VERTICES)
                                && (int'(edge_to) < MAX_VERTICES))
                            begin
                                state_next = S_EA_RD;
                            end
                        end
                        MODE_TRAVERSE:
                        begin
                            pend_next = start_vertex;
                            cur_next  = start_vertex;
                            sp_next   = '0;
                            j_next    = '0;
                            k_next    = VTX_W'(1);
                            ovtx_next = start_vertex;
                            if (int'(start_vertex) >= MAX_VERTICES)
                            begin
                                // start out of range: emit it alone
                                visited_next = '0;
                                ov_next      = 1'b1;
                                olast_next   = 1'b1;
                                oinc_next    = (count_eff > CNT_W'(1));
                            end
                            else
                            begin
                                visited_next = ONE_BIT << start_vertex[AW-1:0];
                                if (count_eff == CNT_W'(1))
                                begin
                                    ov_next    = 1'b1;
                                    olast_next = 1'b1;
                                    oinc_next  = 1'b0;
                                end
                                else
                                begin
                                    state_next = S_RD;
                                end
                            end
                        end
                        MODE_UNUSED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Edge insert: row a |= bit b, then row b |= bit a
            S_EA_RD:
            begin
                adj_ctl.rd_en = 1'b1;
                adj_addr      = a_reg[AW-1:0];
                state_next    = S_EA_WR;
            end
            S_EA_WR:
            begin
                adj_ctl.wr_en = 1'b1;
                adj_addr      = a_reg[AW-1:0];
                adj_wr_data   = adj_rd_data | (ONE_BIT << b_reg[AW-1:0]);
                state_next    = S_EB_RD;
            end
            S_EB_RD:
            begin
                adj_ctl.rd_en = 1'b1;
                adj_addr      = b_reg[AW-1:0];
                state_next    = S_EB_WR;
            end
            S_EB_WR:
            begin
                adj_ctl.wr_en = 1'b1;
                adj_addr      = b_reg[AW-1:0];
                adj_wr_data   = adj_rd_data | (ONE_BIT << a_reg[AW-1:0]);
                state_next    = S_IDLE;
            end

            // Fetch the current vertex row
            S_RD:
            begin
                adj_ctl.rd_en = 1'b1;
                adj_addr      = cur_reg[AW-1:0];
                j_next        = '0;
                state_next    = S_SCAN;
            end

            // One neighbor bit per cycle, push unvisited ones
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    stk_ctl.wr_en = 1'b1;
                    stk_addr      = sp_reg[AW-1:0];
                    stk_wr_data   = j_reg;
                    sp_next       = sp_reg + SPW'(1);
                    visited_next  = visited_reg | (ONE_BIT << j_reg[AW-1:0]);
                end
                if ({1'b0, j_reg} == count_m1)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    j_next = j_reg + VTX_W'(1);
                end
            end

            // Empty stack ends the run; else release the held result and pop
            S_POP:
            begin
                ov_next   = 1'b1;
                ovtx_next = pend_reg;
                if (sp_reg == '0)
                begin
                    olast_next = 1'b1;
                    oinc_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    olast_next    = 1'b0;
                    oinc_next     = 1'b0;
                    stk_ctl.rd_en = 1'b1;
                    stk_addr      = sp_dec[AW-1:0];
                    sp_next       = sp_dec;
                    state_next    = S_POPD;
                end
            end

            // Popped vertex becomes current; final one is emitted at once
            S_POPD:
            begin
                pend_next = stk_rd_data;
                cur_next  = stk_rd_data;
                if ({1'b0, k_reg} == count_m1)
                begin
                    ov_next    = 1'b1;
                    ovtx_next  = stk_rd_data;
                    olast_next = 1'b1;
                    oinc_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + VTX_W'(1);
                    state_next = S_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= CNT_W'(16);
            ov_reg     <= 1'b0;
            sp_reg     <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vcount_reg <= vcount_next;
            ov_reg     <= ov_next;
            sp_reg     <= sp_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
        end
    end

    // Payload and traversal data registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        visited_reg <= visited_next;
        ovtx_reg    <= ovtx_next;
        olast_reg   <= olast_next;
        oinc_reg    <= oinc_next;
    end

    assign out_valid      = ov_reg;
    assign visited_vertex = ovtx_reg;
    assign last           = olast_reg;
    assign incomplete     = oinc_reg;

endmodule

// ===== tb/sv/adjacency_matrix_dfs_order_unit_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the adjacency-matrix DFS order unit: graph mirror, visit order
// prediction and result checking. Depends on amdfs_pkg.
package dfs_order_check_pkg;
    import amdfs_pkg::*;

    // One emitted vertex as seen on the result ports
    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
        logic             incomplete;
    } visit_t;

    // Matches the MAX_VERTICES default of the instance
    localparam int GRAPH_VERTICES = 16;
    localparam int COUNT_CAP = (GRAPH_VERTICES < ADDR_LIMIT) ? GRAPH_VERTICES : ADDR_LIMIT;

    // Vertex count as the traversal uses it: zero acts as one, large values saturate
    function automatic int span_of(logic [CNT_W-1:0] count);
        if (count == '0)
            return 1;
        if (int'(count) > COUNT_CAP)
            return COUNT_CAP;
        return int'(count);
    endfunction

    class dfs_order_scoreboard;
        logic [GRAPH_VERTICES-1:0] adjacency [GRAPH_VERTICES];
        logic [CNT_W-1:0]          vertex_count;
        visit_t                    expected_visits [$];
        int                        errors;

        function new();
            foreach (adjacency[i])
                adjacency[i] = '0;
            vertex_count = CNT_W'(16);
            errors = 0;
        endfunction

        function void note_count(logic [CNT_W-1:0] value);
            vertex_count = value;
        endfunction

        // Visit order of one traversal, appended to the expected results
        function void predict_visit_order(logic [VTX_W-1:0] origin);
            visit_t           order [$];
            visit_t           hit;
            logic [VTX_W-1:0] pending [$];
            logic [GRAPH_VERTICES-1:0] seen;
            logic [VTX_W-1:0] cur;
            int               span;
            int               k;
            int               j;

            span = span_of(vertex_count);
            seen = '0;
            seen[origin] = 1'b1;
            cur = origin;
            hit.vertex = origin;
            hit.last = (span == 1);
            hit.incomplete = 1'b0;
            order.push_back(hit);

            for (k = 1; k < span; k++)
            begin
                // push unvisited neighbors in ascending order, marking on push
                for (j = 0; j < span; j++)
                begin
                    if (adjacency[cur][j] && !seen[j])
                    begin
                        seen[j] = 1'b1;
                        pending.push_back(VTX_W'(j));
                    end
                end
                // nothing left to visit: flag the vertex already emitted
                if (pending.size() == 0)
                begin
                    order[order.size()-1].last = 1'b1;
                    order[order.size()-1].incomplete = 1'b1;
                    break;
                end
                cur = pending.pop_back();
                hit.vertex = cur;
                hit.last = (k == span - 1);
                hit.incomplete = 1'b0;
                order.push_back(hit);
            end

            foreach (order[i])
                expected_visits.push_back(order[i]);
        endfunction

        // Accepted command transaction
        function void note_command(mode_t m, logic [VTX_W-1:0] a,
                                   logic [VTX_W-1:0] b, logic [VTX_W-1:0] s);
            case (m)
                MODE_CLEAR:
                    foreach (adjacency[i])
                        adjacency[i] = '0;
                MODE_ADD_EDGE:
                begin
                    adjacency[a][b] = 1'b1;
                    adjacency[b][a] = 1'b1;
                end
                MODE_TRAVERSE:
                    predict_visit_order(s);
                default:
                    ;
            endcase
        endfunction

        task report(string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        // Accepted result transaction against the oldest expectation
        task check_visit(logic [VTX_W-1:0] got_vertex, logic got_last,
                         logic got_incomplete);
            visit_t want;

            if (expected_visits.size() == 0)
            begin
                report($sformatf("unexpected result, vertex %0d", got_vertex));
                return;
            end
            want = expected_visits.pop_front();
            if (got_vertex !== want.vertex)
                report($sformatf("visited_vertex %0d, want %0d", got_vertex, want.vertex));
            if (got_last !== want.last)
                report($sformatf("last %0b on vertex %0d, want %0b",
                                 got_last, want.vertex, want.last));
            if (got_incomplete !== want.incomplete)
                report($sformatf("incomplete %0b on vertex %0d, want %0b",
                                 got_incomplete, want.vertex, want.incomplete));
        endtask
    endclass

endpackage

// ===== tb/sv/adjacency_matrix_dfs_order_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for adjacency_matrix_dfs_order_unit: directed and random commands,
// config changes between phases. Depends on amdfs_pkg and dfs_order_check_pkg.
module adjacency_matrix_dfs_order_unit_tb;
    import amdfs_pkg::*;
    import dfs_order_check_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_SETTLE = 8;    // settle time for an add edge, which gives no result
    localparam int END_TAIL    = 64;
    localparam int RANDOM_ITEMS = 135;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       mode = '0;
    logic [VTX_W-1:0] edge_from = '0;
    logic [VTX_W-1:0] edge_to = '0;
    logic [VTX_W-1:0] start_vertex = '0;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             out_valid;
    logic [VTX_W-1:0] visited_vertex;
    logic             last;
    logic             incomplete;

    dfs_order_scoreboard sb;
    int cycle_count = 0;
    int random_items = 0;

    adjacency_matrix_dfs_order_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .edge_from      (edge_from),
        .edge_to        (edge_to),
        .start_vertex   (start_vertex),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .visited_vertex (visited_vertex),
        .last           (last),
        .incomplete     (incomplete)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Result monitor: every strobe is a transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
            sb.check_visit(visited_vertex, last, incomplete);
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // One command transaction; start stays high when no gap follows
    task automatic issue_command(mode_t m, logic [VTX_W-1:0] a,
                                 logic [VTX_W-1:0] b, logic [VTX_W-1:0] s, bit calm);
        int gap;
        start        <= 1'b1;
        mode         <= m;
        edge_from    <= a;
        edge_to      <= b;
        start_vertex <= s;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(m, a, b, s);
        if (m != MODE_UNUSED)
            random_items++;
        gap = calm ? 0 : idle_cycles();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all expected results and let a resultless command finish
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.expected_visits.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_vertex_count(logic [CNT_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.note_count(value);
    endtask

    function automatic logic [VTX_W-1:0] pick_vertex(int span);
        if ($urandom_range(0, 4) == 0)
            return VTX_W'($urandom_range(0, 15));
        return VTX_W'($urandom_range(0, span - 1));
    endfunction

    // One random phase: pick a count, optionally build a connected graph, then mix
    task automatic random_phase(int budget);
        logic [CNT_W-1:0] count;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        int  span;
        int  pick;
        int  n;
        int  i;
        bit  calm;

        case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = CNT_W'(1);
            2:       count = CNT_W'(16);
            3:       count = CNT_W'($urandom_range(17, 31));
            4, 5, 6: count = CNT_W'($urandom_range(2, 6));
            default: count = CNT_W'($urandom_range(7, 16));
        endcase
        set_vertex_count(count);
        span = span_of(count);
        calm = ($urandom_range(0, 3) == 0);
        n = 0;

        if ($urandom_range(0, 1) == 1)
        begin
            issue_command(MODE_CLEAR, VTX_W'($urandom), VTX_W'($urandom),
                          VTX_W'($urandom), calm);
            n++;
        end

        // spanning tree so traversals can reach every vertex
        if ($urandom_range(0, 1) == 1)
        begin
            for (i = 1; i < span; i++)
            begin
                a = VTX_W'(i);
                b = VTX_W'($urandom_range(0, i - 1));
                if ($urandom_range(0, 1) == 1)
                    issue_command(MODE_ADD_EDGE, a, b, VTX_W'($urandom), calm);
                else
                    issue_command(MODE_ADD_EDGE, b, a, VTX_W'($urandom), calm);
                n++;
            end
        end

        while (n < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                issue_command(MODE_UNUSED, VTX_W'($urandom), VTX_W'($urandom),
                              VTX_W'($urandom), calm);
            end
            else if (pick < 12)
            begin
                issue_command(MODE_CLEAR, VTX_W'($urandom), VTX_W'($urandom),
                              VTX_W'($urandom), calm);
                n++;
            end
            else if (pick < 62)
            begin
                issue_command(MODE_ADD_EDGE, pick_vertex(span), pick_vertex(span),
                              VTX_W'($urandom), calm);
                n++;
            end
            else
            begin
                issue_command(MODE_TRAVERSE, VTX_W'($urandom), VTX_W'($urandom),
                              pick_vertex(span), calm);
                n++;
            end
        end
        issue_command(MODE_TRAVERSE, VTX_W'($urandom), VTX_W'($urandom),
                      pick_vertex(span), calm);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset count of 16: empty matrix, then edges to the top vertex and self loops
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd0, 4'd15, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd15, 4'd15, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd15, 4'd3, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd5, 4'd5, 4'd0, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd15, 1'b0);
        issue_command(MODE_UNUSED, 4'd15, 4'd15, 4'd15, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd0, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd5, 1'b0);
        issue_command(MODE_CLEAR, 4'd15, 4'd15, 4'd15, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd15, 1'b0);

        // Count of one, then zero which acts as one
        set_vertex_count(CNT_W'(1));
        issue_command(MODE_ADD_EDGE, 4'd7, 4'd8, 4'd0, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd7, 1'b0);
        set_vertex_count(CNT_W'(0));
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd8, 1'b0);

        // Count of four: start above the count, neighbors above it skipped
        set_vertex_count(CNT_W'(4));
        issue_command(MODE_CLEAR, 4'd0, 4'd0, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd10, 4'd2, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd10, 4'd12, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd2, 4'd1, 4'd0, 1'b0);
        issue_command(MODE_ADD_EDGE, 4'd1, 4'd3, 4'd0, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd10, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd0, 1'b0);

        // Count beyond the limit saturates
        set_vertex_count(CNT_W'(31));
        issue_command(MODE_ADD_EDGE, 4'd15, 4'd14, 4'd0, 1'b0);
        issue_command(MODE_TRAVERSE, 4'd0, 4'd0, 4'd15, 1'b0);

        // Random phases
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
            random_phase($urandom_range(6, 28));

        start <= 1'b0;
        while (sb.expected_visits.size() != 0)
            @(posedge clk);
        repeat (END_TAIL) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/amdfs_pkg.sv
rtl/amdfs_adj_mem.sv
rtl/amdfs_stack_mem.sv
rtl/adjacency_matrix_dfs_order_unit.sv
tb/sv/adjacency_matrix_dfs_order_unit_tb_pkg.sv
tb/sv/adjacency_matrix_dfs_order_unit_tb.sv
